### rtl/core/tbcq_pkg.sv
package tbcq_pkg;

  // Commands carried in a result item.
  typedef enum logic [2:0] {
    CMD_RESUME  = 3'd0,
    CMD_START   = 3'd1,
    CMD_PAUSE   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_LOOP    = 3'd4,
    CMD_NOTRACK = 3'd5
  } cmd_t;

  // Button slots, in the order they are examined.
  localparam int BTN_COUNT = 5;
  localparam logic [2:0] BTN_PLAY    = 3'd0;
  localparam logic [2:0] BTN_PAUSE   = 3'd1;
  localparam logic [2:0] BTN_STOP    = 3'd2;
  localparam logic [2:0] BTN_LOOP    = 3'd3;
  localparam logic [2:0] BTN_RESTART = 3'd4;

  // Bit positions of the active-low buttons in the panel bytes.
  localparam int PLAY_BIT    = 1;  // byte a
  localparam int PAUSE_BIT   = 4;  // byte a
  localparam int LOOP_BIT    = 3;  // byte a
  localparam int STOP_BIT    = 2;  // byte b
  localparam int RESTART_BIT = 5;  // byte b

  // Register selects, taken from paddr bit 2.
  localparam logic REG_LOCKOUT     = 1'b0;
  localparam logic REG_TRACK_LIMIT = 1'b1;

  localparam logic [15:0] LOCKOUT_RESET     = 16'd50;
  localparam logic [4:0]  TRACK_LIMIT_RESET = 5'd12;

  typedef struct packed {
    logic              standalone;
    logic signed [4:0] current_track;
    logic              looping_on;
    logic              player_paused;
    logic [31:0]       now_ms;
    logic [7:0]        panel_byte_b;
    logic [7:0]        panel_byte_a;
  } scan_t;

  typedef struct packed {
    logic [15:0] lockout_ms;
    logic [4:0]  track_limit;
  } cfg_t;

  typedef struct packed {
    logic [BTN_COUNT-1:0] press_latches;
    logic [31:0]          last_accept_time;
    logic                 playing_flag;
  } state_t;

  typedef struct packed {
    logic       playing_now;
    logic       loop_value;
    logic [3:0] track;
    cmd_t       command;
  } result_t;

  typedef struct packed {
    logic                 has_result;
    result_t              result;
    logic [BTN_COUNT-1:0] press_latches_nxt;
    logic                 playing_flag_nxt;
  } decision_t;

endpackage

### rtl/core/tbcq_cfg.sv
module tbcq_cfg
  import tbcq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [15:0] lockout_r;
  logic [4:0]  track_limit_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes land in the access phase; the word select is paddr bit 2.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lockout_r     <= LOCKOUT_RESET;
      track_limit_r <= TRACK_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_LOCKOUT:     lockout_r     <= pwdata[15:0];
        REG_TRACK_LIMIT: track_limit_r <= pwdata[4:0];
      endcase
    end
  end

  // Read data is the selected register, zero extended.
  always_comb begin
    unique case (paddr[2])
      REG_LOCKOUT:     prdata = {16'd0, lockout_r};
      REG_TRACK_LIMIT: prdata = {27'd0, track_limit_r};
    endcase
  end

  assign cfg.lockout_ms  = lockout_r;
  assign cfg.track_limit = track_limit_r;

endmodule

### rtl/core/tbcq_decide.sv
module tbcq_decide
  import tbcq_pkg::*;
(
  input  scan_t     scan,
  input  state_t    state,
  input  cfg_t      cfg,
  output decision_t dec
);

  logic [BTN_COUNT-1:0] down;
  logic [BTN_COUNT-1:0] eligible;
  logic [31:0]          elapsed;
  logic                 window_open;
  logic                 found;
  logic [2:0]           btn_idx;
  logic                 track_ok;

  // Buttons are active low in the panel bytes.
  always_comb begin
    down[BTN_PLAY]    = ~scan.panel_byte_a[PLAY_BIT];
    down[BTN_PAUSE]   = ~scan.panel_byte_a[PAUSE_BIT];
    down[BTN_STOP]    = ~scan.panel_byte_b[STOP_BIT];
    down[BTN_LOOP]    = ~scan.panel_byte_a[LOOP_BIT];
    down[BTN_RESTART] = ~scan.panel_byte_b[RESTART_BIT];
  end

  // Shared lockout timer, compared with wrapping subtraction.
  assign elapsed     = scan.now_ms - state.last_accept_time;
  assign window_open = elapsed > {16'd0, cfg.lockout_ms};
  assign eligible    = down & ~state.press_latches;

  // The first newly pressed button in scan order wins the timer.
  always_comb begin
    found   = 1'b0;
    btn_idx = BTN_PLAY;
    for (int i = 0; i < BTN_COUNT; i++) begin
      if (!found && eligible[i]) begin
        found   = 1'b1;
        btn_idx = i[2:0];
      end
    end
  end

  assign track_ok = !scan.current_track[4] &&
                    ({1'b0, scan.current_track[3:0]} < cfg.track_limit);

  // Command selection and next latch and playing state.
  always_comb begin
    dec.has_result         = !scan.standalone && window_open && found;
    dec.result.command     = CMD_RESUME;
    dec.result.track       = 4'd0;
    dec.result.loop_value  = 1'b0;
    dec.playing_flag_nxt   = state.playing_flag;

    unique case (btn_idx)
      BTN_PLAY: begin
        if (scan.player_paused) begin
          dec.result.command   = CMD_RESUME;
          dec.playing_flag_nxt = 1'b1;
        end else if (track_ok) begin
          dec.result.command   = CMD_START;
          dec.result.track     = scan.current_track[3:0];
          dec.playing_flag_nxt = 1'b1;
        end else begin
          dec.result.command   = CMD_NOTRACK;
        end
      end
      BTN_PAUSE: begin
        dec.result.command = scan.player_paused ? CMD_RESUME : CMD_PAUSE;
      end
      BTN_STOP: begin
        dec.result.command   = CMD_STOP;
        dec.playing_flag_nxt = 1'b0;
      end
      BTN_LOOP: begin
        dec.result.command    = CMD_LOOP;
        dec.result.loop_value = ~scan.looping_on;
      end
      BTN_RESTART: begin
        if (track_ok) begin
          dec.result.command   = CMD_START;
          dec.result.track     = scan.current_track[3:0];
          dec.playing_flag_nxt = 1'b1;
        end else begin
          dec.result.command   = CMD_NOTRACK;
        end
      end
      default: begin
        dec.result.command = CMD_RESUME;
      end
    endcase

    // Without an accepted press the playing flag stays.
    if (!dec.has_result) begin
      dec.playing_flag_nxt = state.playing_flag;
    end
    dec.result.playing_now = dec.playing_flag_nxt;

    // Latches arm on the accepted press and clear on release; standalone scans leave them as they are.
    dec.press_latches_nxt = state.press_latches;
    if (!scan.standalone) begin
      for (int i = 0; i < BTN_COUNT; i++) begin
        if (dec.has_result && (btn_idx == i[2:0])) begin
          dec.press_latches_nxt[i] = 1'b1;
        end else if (!down[i]) begin
          dec.press_latches_nxt[i] = 1'b0;
        end
      end
    end
  end

endmodule

### rtl/core/transport_button_command_qualifier.sv
// A result item passes through the input register and the result register.
// Throughput: one scan per cycle unless a result waits on a stalled output;
// the press latches, lockout time stamp and playing flag update as a scan
// leaves the input register; a scan with no result is never held by a stall.
// Reset (synchronous, active low) clears all state and both stages and sets
// the lockout to 50 ms and the track limit to 12.
module transport_button_command_qualifier
  import tbcq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Scan input.
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: panel_byte_a[7:0], panel_byte_b[15:8], now_ms[47:16],
  // player_paused[48], looping_on[49], current_track[54:50], zero[55].
  input  logic [55:0] in_tdata,
  // in_tuser: standalone[0].
  input  logic        in_tuser,
  // Result output.
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: command[2:0], track[6:3], loop_value[7], playing_now[8],
  // zero[15:9].
  output logic [15:0] out_tdata,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t      cfg;
  state_t    state_r;
  decision_t dec;
  scan_t     s1_scan_r;
  logic      s1_valid_r;
  result_t   out_res_r;
  logic      out_valid_r;
  logic      out_free;
  logic      s1_go;
  logic      in_fire;

  tbcq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tbcq_decide u_decide (
    .scan  (s1_scan_r),
    .state (state_r),
    .cfg   (cfg),
    .dec   (dec)
  );

  // Handshake between the input register and the result register.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!dec.has_result || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
    if (in_fire) begin
      s1_scan_r.panel_byte_a  <= in_tdata[7:0];
      s1_scan_r.panel_byte_b  <= in_tdata[15:8];
      s1_scan_r.now_ms        <= in_tdata[47:16];
      s1_scan_r.player_paused <= in_tdata[48];
      s1_scan_r.looping_on    <= in_tdata[49];
      s1_scan_r.current_track <= in_tdata[54:50];
      s1_scan_r.standalone    <= in_tuser;
    end
  end

  // Qualifier state advances as each scan leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.press_latches    <= '0;
      state_r.last_accept_time <= 32'd0;
      state_r.playing_flag     <= 1'b0;
    end else if (s1_go) begin
      state_r.press_latches <= dec.press_latches_nxt;
      state_r.playing_flag  <= dec.playing_flag_nxt;
      if (dec.has_result) begin
        state_r.last_accept_time <= s1_scan_r.now_ms;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && dec.has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_go && dec.has_result) begin
      out_res_r <= dec.result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.playing_now, out_res_r.loop_value,
                       out_res_r.track, out_res_r.command};

`ifndef ASSERT_OFF
  // A stop result always reports playback stopped.
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.command == CMD_STOP) |-> !out_res_r.playing_now)
    else $error("stop result with playing flag set");

  // A start result always reports playback running.
  a_start_sets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.command == CMD_START) |-> out_res_r.playing_now)
    else $error("start result without playing flag");

  // Track and loop fields are zero outside their own commands.
  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |->
      ((out_res_r.command == CMD_START) || (out_res_r.track == 4'd0)) &&
      ((out_res_r.command == CMD_LOOP) || !out_res_r.loop_value))
    else $error("result field set for wrong command");

  // An accepted press records its time stamp for the lockout.
  a_time_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && dec.has_result |=> state_r.last_accept_time == $past(s1_scan_r.now_ms))
    else $error("lockout time stamp not updated");
`endif

endmodule
